// ===== hdl/stepper_accel_ramp_generator_unit_defines.svh =====
// assertion helpers for the ramp generator
`ifndef STEPPER_ACCEL_RAMP_GENERATOR_UNIT_DEFINES_SVH
`define STEPPER_ACCEL_RAMP_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication on clk_i, off during reset
`define SARG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, off during reset
`define SARG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sarg_pkg.sv =====
`timescale 1ns / 1ps
package sarg_pkg;

  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned RAMP_W     = 15;
  localparam int unsigned START_W    = 16;
  localparam int unsigned STEPS_W    = 15;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned IV_W       = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned FRACTION_BITS_DEF = 16;

  localparam logic [SHIFT_W-1:0] ACCEL_SHIFT_RST  = SHIFT_W'(8);
  localparam logic [RAMP_W-1:0]  RAMP_STEPS_RST   = RAMP_W'(500);
  localparam logic [START_W-1:0] START_PERIOD_RST = START_W'(6000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_SHIFT  = 2'd0,
    CFG_RAMP_STEPS   = 2'd1,
    CFG_START_PERIOD = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [SHIFT_W-1:0] accel_shift;
    logic [RAMP_W-1:0]  ramp_steps;
    logic [START_W-1:0] start_period;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic [STEPS_W-1:0] x_steps;
    logic [STEPS_W-1:0] y_steps;
  } in_t;

  typedef struct packed {
    logic                x_step;
    logic                y_step;
    logic                x_busy;
    logic                y_busy;
    logic [PERIOD_W-1:0] x_period;
    logic [PERIOD_W-1:0] y_period;
  } out_t;

  typedef struct packed {
    logic                step;
    logic                busy;
    logic [PERIOD_W-1:0] period;
  } axis_res_t;

endpackage

// ===== hdl/sarg_cfg.sv =====
`timescale 1ns / 1ps
module sarg_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sarg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sarg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output sarg_pkg::cfg_t                   cfg_o
);
  import sarg_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_shift  <= ACCEL_SHIFT_RST;
      cfg_q.ramp_steps   <= RAMP_STEPS_RST;
      cfg_q.start_period <= START_PERIOD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ACCEL_SHIFT: begin
          cfg_q.accel_shift <= cfg_data_i[SHIFT_W-1:0];
        end
        CFG_RAMP_STEPS: begin
          cfg_q.ramp_steps <= cfg_data_i[RAMP_W-1:0];
        end
        CFG_START_PERIOD: begin
          cfg_q.start_period <= cfg_data_i[START_W-1:0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

endmodule

// ===== hdl/sarg_axis.sv =====
`timescale 1ns / 1ps
module sarg_axis #(
  parameter int unsigned FRACTION_BITS = sarg_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           start_i,
  input  logic [sarg_pkg::STEPS_W-1:0]   steps_i,
  input  sarg_pkg::cfg_t                 cfg_i,
  output sarg_pkg::axis_res_t            res_o
);
  import sarg_pkg::*;

  localparam int unsigned WIDE_W = START_W + FRACTION_BITS;
  localparam int unsigned INT_W  = IV_W - FRACTION_BITS;

  logic [STEPS_W-1:0]  rem_q, rem_d;
  logic [STEPS_W-1:0]  accel_q, accel_d;
  logic [STEPS_W-1:0]  brake_q, brake_d;
  logic [IV_W-1:0]     iv_q, iv_d;
  logic [TICK_W-1:0]   tick_q, tick_d;

  logic [WIDE_W-1:0]   iv_wide;
  logic [IV_W-1:0]     iv_start;
  logic [INT_W-1:0]    int_cur, int_nxt;
  logic [PERIOD_W-1:0] cmp_cur, cmp_nxt;
  logic [TICK_W-1:0]   tick_inc;
  logic [STEPS_W-1:0]  rem_dec;
  logic [STEPS_W-1:0]  half_steps;
  logic [IV_W-1:0]     delta;
  logic [IV_W:0]       iv_sum;
  logic [IV_W-1:0]     iv_up, iv_dn;
  logic                step;

  assign iv_wide = {cfg_i.start_period, {FRACTION_BITS{1'b0}}};
  assign int_cur = iv_q[IV_W-1:FRACTION_BITS];
  assign int_nxt = iv_d[IV_W-1:FRACTION_BITS];

  generate
    if (WIDE_W > IV_W) begin : g_start_sat
      assign iv_start = (|iv_wide[WIDE_W-1:IV_W]) ? '1 : iv_wide[IV_W-1:0];
    end else begin : g_start_pad
      assign iv_start = IV_W'(iv_wide);
    end
    if (INT_W > PERIOD_W) begin : g_cmp_sat
      assign cmp_cur = (|int_cur[INT_W-1:PERIOD_W]) ? '1 : int_cur[PERIOD_W-1:0];
      assign cmp_nxt = (|int_nxt[INT_W-1:PERIOD_W]) ? '1 : int_nxt[PERIOD_W-1:0];
    end else begin : g_cmp_pad
      assign cmp_cur = PERIOD_W'(int_cur);
      assign cmp_nxt = PERIOD_W'(int_nxt);
    end
  endgenerate

  assign tick_inc   = tick_q + 1'b1;
  assign rem_dec    = rem_q - 1'b1;
  assign half_steps = steps_i >> 1;
  assign delta      = iv_q >> cfg_i.accel_shift;
  assign iv_sum     = {1'b0, iv_q} + {1'b0, delta};
  assign iv_up      = iv_sum[IV_W] ? '1 : iv_sum[IV_W-1:0];
  assign iv_dn      = iv_q - delta;

  always_comb begin
    rem_d   = rem_q;
    accel_d = accel_q;
    brake_d = brake_q;
    iv_d    = iv_q;
    tick_d  = tick_q;
    step    = 1'b0;
    if (start_i) begin
      rem_d = steps_i;
      if ({1'b0, steps_i} < {cfg_i.ramp_steps, 1'b0}) begin
        accel_d = half_steps;
        brake_d = steps_i - half_steps;
      end else begin
        accel_d = cfg_i.ramp_steps;
        brake_d = cfg_i.ramp_steps;
      end
      iv_d   = iv_start;
      tick_d = '0;
    end else if (rem_q != '0) begin
      if (tick_inc < cmp_cur) begin
        tick_d = tick_inc;
      end else begin
        step   = 1'b1;
        tick_d = '0;
        rem_d  = rem_dec;
        if (rem_dec < brake_q) begin
          iv_d = iv_up;
        end else if (accel_q != '0) begin
          iv_d    = iv_dn;
          accel_d = accel_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      accel_q <= '0;
      brake_q <= '0;
      iv_q    <= '0;
      tick_q  <= '0;
    end else if (en_i) begin
      rem_q   <= rem_d;
      accel_q <= accel_d;
      brake_q <= brake_d;
      iv_q    <= iv_d;
      tick_q  <= tick_d;
    end
  end

  assign res_o.step   = step;
  assign res_o.busy   = (rem_d != '0);
  assign res_o.period = cmp_nxt;

endmodule

// ===== hdl/stepper_accel_ramp_generator_unit.sv =====
// trapezoidal two-axis step generator
// path: an accepted transaction passes the input register, then the output register
// throughput: one transaction per cycle unless out_stall_i holds the output register
// reset: asynchronous active low, clears both axes and the pipeline, registers to defaults
`timescale 1ns / 1ps
`include "stepper_accel_ramp_generator_unit_defines.svh"
module stepper_accel_ramp_generator_unit #(
  parameter int unsigned FRACTION_BITS = sarg_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sarg_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sarg_pkg::out_t                  out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sarg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sarg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sarg_pkg::*;

  cfg_t      cfg;
  in_t       s1_q;
  logic      s1_valid_q;
  out_t      out_q;
  logic      out_valid_q;
  logic      out_free;
  logic      adv;
  logic      in_acc;
  axis_res_t x_res, y_res;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  sarg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sarg_axis #(.FRACTION_BITS(FRACTION_BITS)) u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .start_i (s1_q.cmd),
    .steps_i (s1_q.x_steps),
    .cfg_i   (cfg),
    .res_o   (x_res)
  );

  sarg_axis #(.FRACTION_BITS(FRACTION_BITS)) u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .start_i (s1_q.cmd),
    .steps_i (s1_q.y_steps),
    .cfg_i   (cfg),
    .res_o   (y_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_data_i;
    end
    if (adv) begin
      out_q.x_step   <= x_res.step;
      out_q.y_step   <= y_res.step;
      out_q.x_busy   <= x_res.busy;
      out_q.y_busy   <= y_res.busy;
      out_q.x_period <= x_res.period;
      out_q.y_period <= y_res.period;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SARG_ASSERT_IMPL(a_hold_blocks_input, s1_valid_q && out_valid_q && out_stall_i, in_stall_o, "input taken while both stages held")
  `SARG_ASSERT_NEXT(a_adv_fills_out, adv, out_valid_q, "advanced transaction lost before output")
  `SARG_ASSERT_NEXT(a_acc_fills_s1, in_acc, s1_valid_q, "accepted transaction lost in input register")
  `SARG_ASSERT_NEXT(a_start_no_step, adv && s1_q.cmd, !out_q.x_step && !out_q.y_step, "step pulse on a start transaction")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import sarg_pkg::*;

  localparam int unsigned FRAC = FRACTION_BITS_DEF;
  localparam int unsigned RANDOM_ITEMS = 840;
  localparam int unsigned PHASES = 6;
  localparam int unsigned SLOW_PERIOD = 40;
  localparam longint unsigned LIMIT_NS = 3_000_000;

  typedef enum logic [1:0] {ROW_TICK, ROW_START, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    cfg_idx_e    idx;
    int unsigned a;
    int unsigned b;
    bit          pin;
    out_t        res;
  } dir_row_t;

  typedef struct {
    logic [15:0] remaining;
    logic [15:0] accel_left;
    logic [15:0] brake_len;
    logic [31:0] interval;
    logic [15:0] tick_count;
  } axis_st_t;

  localparam out_t RES_ZERO      = '0;
  localparam out_t RES_IDLE_6000 = '{1'b0, 1'b0, 1'b0, 1'b0, 16'd6000, 16'd6000};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_t in_data = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // pinned expectation travels with the transaction
  logic pin_en = 1'b0;
  out_t pin_res = '0;

  logic [SHIFT_W-1:0] shift_r = ACCEL_SHIFT_RST;
  logic [RAMP_W-1:0] ramp_r = RAMP_STEPS_RST;
  logic [START_W-1:0] period_r = START_PERIOD_RST;
  axis_st_t x_ax = '{16'd0, 16'd0, 16'd0, 32'd0, 16'd0};
  axis_st_t y_ax = '{16'd0, 16'd0, 16'd0, 32'd0, 16'd0};

  out_t motion_q [$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_steps = 0;
  int n_writes = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  dir_row_t dir_rows [37] = '{
    '{ROW_TICK,  CFG_ACCEL_SHIFT,  0,     0,     1'b1, RES_ZERO},
    '{ROW_START, CFG_ACCEL_SHIFT,  0,     0,     1'b1, RES_IDLE_6000},
    '{ROW_TICK,  CFG_ACCEL_SHIFT,  0,     0,     1'b1, RES_IDLE_6000},
    '{ROW_START, CFG_ACCEL_SHIFT,  32767, 1,     1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b1, 16'd6000, 16'd6000}},
    '{ROW_TICK,  CFG_ACCEL_SHIFT,  0,     0,     1'b0, RES_ZERO},
    '{ROW_REG,   CFG_ACCEL_SHIFT,  0,     0,     1'b0, RES_ZERO},
    '{ROW_REG,   CFG_RAMP_STEPS,   0,     0,     1'b0, RES_ZERO},
    '{ROW_REG,   CFG_START_PERIOD, 0,     0,     1'b0, RES_ZERO},
    '{ROW_START, CFG_ACCEL_SHIFT,  3,     32767, 1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b1, 16'd0, 16'd0}},
    '{ROW_TICK,  CFG_ACCEL_SHIFT,  0,     0,     1'b0, RES_ZERO},
    '{ROW_TICK,  CFG_ACCEL_SHIFT,  0,     0,     1'b0, RES_ZERO},
    '{ROW_TICK,  CFG_ACCEL_SHIFT,  0,     0,     1'b0, RES_ZERO},
    '{ROW_TICK,  CFG_ACCEL_SHIFT,  0,     0,     1'b0, RES_ZERO},
    '{ROW_REG,   CFG_ACCEL_SHIFT,  15,    0,     1'b0, RES_ZERO},
    '{ROW_REG,   CFG_RAMP_STEPS,   32767, 0,     1'b0, RES_ZERO},
    '{ROW_REG,   CFG_START_PERIOD, 65535, 0,     1'b0, RES_ZERO},
    '{ROW_START, CFG_ACCEL_SHIFT,  1,     2,     1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b1, 16'd65535, 16'd65535}},
    '{ROW_TICK,  CFG_ACCEL_SHIFT,  0,     0,     1'b0, RES_ZERO},
    '{ROW_REG,   CFG_ACCEL_SHIFT,  0,     0,     1'b0, RES_ZERO},
    '{ROW_REG,   CFG_RAMP_STEPS,   2,     0,     1'b0, RES_ZERO},
    '{ROW_REG,   CFG_START_PERIOD, 1,     0,     1'b0, RES_ZERO},
    '{ROW_START, CFG_ACCEL_SHIFT,  5,     1,     1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b1, 16'd1, 16'd1}},
    '{ROW_TICK,  CFG_ACCEL_SHIFT,  0,     0,     1'b0, RES_ZERO},
    '{ROW_TICK,  CFG_ACCEL_SHIFT,  0,     0,     1'b0, RES_ZERO},
    '{ROW_TICK,  CFG_ACCEL_SHIFT,  0,     0,     1'b0, RES_ZERO},
    '{ROW_TICK,  CFG_ACCEL_SHIFT,  0,     0,     1'b0, RES_ZERO},
    '{ROW_TICK,  CFG_ACCEL_SHIFT,  0,     0,     1'b0, RES_ZERO},
    '{ROW_REG,   CFG_ACCEL_SHIFT,  1,     0,     1'b0, RES_ZERO},
    '{ROW_REG,   CFG_RAMP_STEPS,   3,     0,     1'b0, RES_ZERO},
    '{ROW_REG,   CFG_START_PERIOD, 2,     0,     1'b0, RES_ZERO},
    '{ROW_START, CFG_ACCEL_SHIFT,  7,     6,     1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b1, 16'd2, 16'd2}},
    '{ROW_TICK,  CFG_ACCEL_SHIFT,  0,     0,     1'b0, RES_ZERO},
    '{ROW_TICK,  CFG_ACCEL_SHIFT,  0,     0,     1'b0, RES_ZERO},
    '{ROW_TICK,  CFG_ACCEL_SHIFT,  0,     0,     1'b0, RES_ZERO},
    '{ROW_TICK,  CFG_ACCEL_SHIFT,  0,     0,     1'b0, RES_ZERO},
    '{ROW_TICK,  CFG_ACCEL_SHIFT,  0,     0,     1'b0, RES_ZERO},
    '{ROW_START, CFG_ACCEL_SHIFT,  2,     2,     1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b1, 16'd2, 16'd2}}
  };

  stepper_accel_ramp_generator_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [15:0] axis_period(axis_st_t a);
    logic [31:0] p;
    p = a.interval >> FRAC;
    return (p > 32'hFFFF) ? 16'hFFFF : p[15:0];
  endfunction

  function automatic void start_axis(inout axis_st_t a, input logic [STEPS_W-1:0] steps);
    logic [47:0] iv;
    iv = 48'(period_r) << FRAC;
    a.remaining = 16'(steps);
    if ({1'b0, steps} < {ramp_r, 1'b0}) begin
      a.accel_left = 16'(steps >> 1);
      a.brake_len = 16'(steps) - a.accel_left;
    end else begin
      a.accel_left = 16'(ramp_r);
      a.brake_len = 16'(ramp_r);
    end
    a.interval = (iv > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : iv[31:0];
    a.tick_count = '0;
  endfunction

  function automatic logic advance_axis(inout axis_st_t a);
    logic [31:0] delta;
    logic [32:0] sum;
    if (a.remaining == 16'd0) return 1'b0;
    a.tick_count = a.tick_count + 16'd1;
    if (a.tick_count < axis_period(a)) return 1'b0;
    a.tick_count = '0;
    a.remaining = a.remaining - 16'd1;
    delta = a.interval >> shift_r;
    if (a.remaining < a.brake_len) begin
      sum = {1'b0, a.interval} + {1'b0, delta};
      a.interval = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end else if (a.accel_left != 16'd0) begin
      a.interval = a.interval - delta;
      a.accel_left = a.accel_left - 16'd1;
    end
    return 1'b1;
  endfunction

  function automatic out_t predict_motion(in_t it);
    out_t r;
    r = '0;
    if (it.cmd) begin
      start_axis(x_ax, it.x_steps);
      start_axis(y_ax, it.y_steps);
    end else begin
      r.x_step = advance_axis(x_ax);
      r.y_step = advance_axis(y_ax);
    end
    r.x_busy = (x_ax.remaining != 16'd0);
    r.y_busy = (y_ax.remaining != 16'd0);
    r.x_period = axis_period(x_ax);
    r.y_period = axis_period(y_ax);
    return r;
  endfunction

  function automatic in_t random_move();
    in_t it;
    it.x_steps = STEPS_W'($urandom_range(0, 32767));
    it.y_steps = STEPS_W'($urandom_range(0, 32767));
    it.cmd = ($urandom_range(99) < 4);
    // short moves mostly, so that most of them run to the end
    if (it.cmd && $urandom_range(3) != 0) begin
      it.x_steps = STEPS_W'($urandom_range(0, 40));
      it.y_steps = STEPS_W'($urandom_range(0, 40));
    end
    return it;
  endfunction

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    out_t got;
    out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (motion_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = motion_q.pop_front();
          check_field("x_step", want.x_step, got.x_step);
          check_field("y_step", want.y_step, got.y_step);
          check_field("x_busy", want.x_busy, got.x_busy);
          check_field("y_busy", want.y_busy, got.y_busy);
          check_field("x_period", want.x_period, got.x_period);
          check_field("y_period", want.y_period, got.y_period);
          n_results++;
          n_steps += int'(got.x_step) + int'(got.y_step);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_e'(cfg_index))
          CFG_ACCEL_SHIFT:  shift_r = cfg_data[SHIFT_W-1:0];
          CFG_RAMP_STEPS:   ramp_r = cfg_data[RAMP_W-1:0];
          CFG_START_PERIOD: period_r = cfg_data[START_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        want = predict_motion(in_data);
        motion_q.push_back(pin_en ? pin_res : want);
        n_items++;
      end
    end
  end

  task automatic send_item(in_t it, logic pin, out_t res);
    in_valid <= 1'b1;
    in_data <= it;
    pin_en <= pin;
    pin_res <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (motion_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_writes++;
  endtask

  initial begin
    in_t it;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        quiesce();
        write_reg(dir_rows[i].idx, CFG_DATA_W'(dir_rows[i].a));
      end else begin
        it.cmd = (dir_rows[i].kind == ROW_START);
        it.x_steps = STEPS_W'(dir_rows[i].a);
        it.y_steps = STEPS_W'(dir_rows[i].b);
        send_item(it, dir_rows[i].pin, dir_rows[i].res);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      quiesce();
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 73;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 73;
        end
        default: begin
          send_idle_pct = 33;
          recv_stall_pct = 33;
        end
      endcase
      write_reg(CFG_ACCEL_SHIFT, CFG_DATA_W'($urandom_range(0, 15)));
      write_reg(CFG_RAMP_STEPS, (ph == 1) ? CFG_DATA_W'(32767)
                                          : CFG_DATA_W'($urandom_range(0, 10)));
      write_reg(CFG_START_PERIOD, (ph == 4) ? CFG_DATA_W'($urandom_range(60, 200))
                                            : CFG_DATA_W'($urandom_range(0, 9)));
      for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
        // hold off until every result has drained
        if (ph == 2 && k == 75) quiesce();
        while ($urandom_range(99) < send_idle_pct) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
        send_item(random_move(), 1'b0, RES_ZERO);
      end
    end

    // zero shift with a one-step ramp: braking doubles the interval
    quiesce();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CFG_ACCEL_SHIFT, '0);
    write_reg(CFG_RAMP_STEPS, CFG_DATA_W'(1));
    write_reg(CFG_START_PERIOD, CFG_DATA_W'(SLOW_PERIOD));
    it.cmd = 1'b1;
    it.x_steps = STEPS_W'(1);
    it.y_steps = STEPS_W'(2);
    send_item(it, 1'b0, RES_ZERO);
    repeat (SLOW_PERIOD + 4) begin
      it = random_move();
      it.cmd = 1'b0;
      send_item(it, 1'b0, RES_ZERO);
    end

    in_valid <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("ran %0d transactions and %0d register writes over all idling mixes",
             n_items, n_writes);
    $display("checked %0d results carrying %0d step pulses", n_results, n_steps);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("%0t: timed out with %0d results outstanding", $time, motion_q.size());
    $display("tb: failure");
    $finish;
  end

endmodule
